FILE: src/ebw_pkg.sv
// ----------------------------------------------------------------------------
// ebw_pkg
// Shared modes, widths and controller/datapath handshake types for the
// Exp-Golomb bit writer.
// ----------------------------------------------------------------------------
`default_nettype none

package ebw_pkg;

  localparam logic [2:0] MODE_FIXED = 3'd0;
  localparam logic [2:0] MODE_UEG   = 3'd1;
  localparam logic [2:0] MODE_SEG   = 3'd2;
  localparam logic [2:0] MODE_ALIGN = 3'd3;
  localparam logic [2:0] MODE_TRAIL = 3'd4;

  localparam int unsigned ModeW       = 3;
  localparam int unsigned CountW      = 6;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned ByteBits    = 8;
  localparam int unsigned MaxFixedBits = 32;
  localparam int unsigned CodeW       = ValueW + 1;

  typedef struct packed {
    logic load;
    logic coarse;
    logic fine;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic can_step;
    logic more;
  } sts_t;

endpackage

`default_nettype wire

FILE: src/ebw_in_if.sv
// ----------------------------------------------------------------------------
// ebw_in_if
// Syntax element channel: valid/ready with one element per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ebw_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic [5:0]         bit_count;
  logic [31:0]        unsigned_value;
  logic signed [31:0] signed_value;
  logic               fill_bit;

  modport source (
    output valid, mode, bit_count, unsigned_value, signed_value, fill_bit,
    input  ready
  );
  modport sink (
    input  valid, mode, bit_count, unsigned_value, signed_value, fill_bit,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/ebw_out_if.sv
// ----------------------------------------------------------------------------
// ebw_out_if
// Byte stream channel: valid/ready with one byte and its last flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ebw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

`default_nettype wire

FILE: src/ebw_datapath.sv
// ----------------------------------------------------------------------------
// ebw_datapath
// Code formation, two-step normalization, byte packer and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ebw_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ebw_pkg::cmd_t      cmd_i,
  input  wire logic [2:0]         mode_i,
  input  wire logic [5:0]         bit_count_i,
  input  wire logic [31:0]        unsigned_value_i,
  input  wire logic signed [31:0] signed_value_i,
  input  wire logic               fill_bit_i,
  input  wire logic               out_ready_i,
  output ebw_pkg::sts_t           sts_o,
  output logic                    out_valid_o,
  output logic [7:0]              out_byte_o,
  output logic                    last_byte_o
);

  function automatic logic [2:0] lead_one(input logic [7:0] v);
    logic [2:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) p = 3'(i);
    end
    return p;
  endfunction

  logic [ebw_pkg::CodeW-1:0] code_q, code_d;
  logic [ebw_pkg::CodeW-1:0] s_q;
  logic [5:0]                z_q, r_q;
  logic [7:0]                acc_q;
  logic [2:0]                pc_q;
  logic                      out_valid_q;
  logic [7:0]                out_byte_q;
  logic                      out_last_q;

  logic [5:0]                cnt_sat, fix_shift;
  logic [ebw_pkg::CodeW-1:0] fix_src;
  logic [31:0]               s_raw, mag;

  logic [31:0]               crs_t;
  logic [5:0]                crs_w;
  logic [2:0]                fine_p;

  logic [3:0]                space, kz, rem, ks, take, fill;
  logic [7:0]                top8, bits, acc_new;
  logic [5:0]                z_n, r_n;
  logic                      emit, last;

  always_comb begin
    cnt_sat   = (bit_count_i > 6'(ebw_pkg::MaxFixedBits)) ?
                6'(ebw_pkg::MaxFixedBits) : bit_count_i;
    fix_shift = 6'(ebw_pkg::MaxFixedBits) - cnt_sat;
    fix_src   = {unsigned_value_i, 1'b0} << fix_shift;
    s_raw     = unsigned'(signed_value_i);
    mag       = ~s_raw + 32'd1;
    if (mode_i == ebw_pkg::MODE_UEG) begin
      code_d = {1'b0, unsigned_value_i} + 33'd1;
    end else if (s_raw[31] || s_raw == 32'd0) begin
      code_d = {mag, 1'b1};
    end else begin
      code_d = {s_raw, 1'b0};
    end
  end

  always_comb begin
    priority if (code_q[31:24] != 8'd0) begin
      crs_t = code_q[31:0];
      crs_w = 6'd24;
    end else if (code_q[23:16] != 8'd0) begin
      crs_t = code_q[31:0] << 8;
      crs_w = 6'd16;
    end else if (code_q[15:8] != 8'd0) begin
      crs_t = code_q[31:0] << 16;
      crs_w = 6'd8;
    end else begin
      crs_t = code_q[31:0] << 24;
      crs_w = 6'd0;
    end
    fine_p = lead_one(s_q[32:25]);
  end

  always_comb begin
    space   = 4'(ebw_pkg::ByteBits) - {1'b0, pc_q};
    kz      = (z_q < 6'(space)) ? 4'(z_q) : space;
    rem     = space - kz;
    ks      = (r_q < 6'(rem)) ? 4'(r_q) : rem;
    take    = kz + ks;
    top8    = s_q[32:25];
    bits    = top8 >> (4'(ebw_pkg::ByteBits) - ks);
    acc_new = (acc_q << take) | bits;
    fill    = {1'b0, pc_q} + take;
    emit    = (fill == 4'(ebw_pkg::ByteBits));
    z_n     = z_q - 6'(kz);
    r_n     = r_q - 6'(ks);
    last    = ({1'b0, z_n} + {1'b0, r_n}) < 7'(ebw_pkg::ByteBits);
    sts_o.can_step = !emit || !out_valid_q || out_ready_i;
    sts_o.more     = (z_n != 6'd0) || (r_n != 6'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.step && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.step) begin
        if (emit) begin
          acc_q <= '0;
          pc_q  <= '0;
        end else begin
          acc_q <= acc_new;
          pc_q  <= fill[2:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      case (mode_i)
        ebw_pkg::MODE_FIXED: begin
          s_q <= fix_src;
          z_q <= '0;
          r_q <= cnt_sat;
        end
        ebw_pkg::MODE_UEG, ebw_pkg::MODE_SEG: begin
          code_q <= code_d;
        end
        ebw_pkg::MODE_ALIGN: begin
          s_q <= {ebw_pkg::CodeW{fill_bit_i}};
          z_q <= '0;
          r_q <= {3'b000, 3'(3'd0 - pc_q)};
        end
        ebw_pkg::MODE_TRAIL: begin
          s_q <= {1'b1, {(ebw_pkg::CodeW-1){1'b0}}};
          z_q <= '0;
          r_q <= 6'(4'(ebw_pkg::ByteBits) - {1'b0, pc_q});
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.coarse) begin
      if (code_q[ebw_pkg::CodeW-1]) begin
        s_q <= code_q;
        z_q <= 6'(ebw_pkg::CodeW - 1);
      end else begin
        s_q <= {crs_t, 1'b0};
        z_q <= crs_w;
      end
    end
    if (cmd_i.fine) begin
      if (z_q == 6'(ebw_pkg::CodeW - 1)) begin
        r_q <= 6'(ebw_pkg::CodeW);
      end else begin
        s_q <= s_q << (3'd7 - fine_p);
        z_q <= z_q + 6'(fine_p);
        r_q <= z_q + 6'(fine_p) + 6'd1;
      end
    end
    if (cmd_i.step) begin
      s_q <= s_q << ks;
      z_q <= z_n;
      r_q <= r_n;
      if (emit) begin
        out_byte_q <= acc_new;
        out_last_q <= last;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_byte_o = out_last_q;

endmodule

`default_nettype wire

FILE: src/ebw_ctrl.sv
// ----------------------------------------------------------------------------
// ebw_ctrl
// Sequencer: accept an element, normalize Golomb codes, drive packing steps.
// ----------------------------------------------------------------------------
`default_nettype none

module ebw_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [2:0]    mode_i,
  input  wire ebw_pkg::sts_t sts_i,
  output logic               in_ready_o,
  output ebw_pkg::cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COARSE,
    ST_FINE,
    ST_STREAM
  } state_e;

  state_e state_q;
  logic   ready_q;
  logic   mode_ok, golomb;

  always_comb begin
    golomb  = (mode_i == ebw_pkg::MODE_UEG) || (mode_i == ebw_pkg::MODE_SEG);
    mode_ok = golomb || (mode_i == ebw_pkg::MODE_FIXED) ||
              (mode_i == ebw_pkg::MODE_ALIGN) || (mode_i == ebw_pkg::MODE_TRAIL);
    cmd_o.load   = in_valid_i && ready_q && mode_ok;
    cmd_o.coarse = (state_q == ST_COARSE);
    cmd_o.fine   = (state_q == ST_FINE);
    cmd_o.step   = (state_q == ST_STREAM) && sts_i.can_step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.load) begin
            state_q <= golomb ? ST_COARSE : ST_STREAM;
            ready_q <= 1'b0;
          end
        end
        ST_COARSE: state_q <= ST_FINE;
        ST_FINE:   state_q <= ST_STREAM;
        ST_STREAM: begin
          if (cmd_o.step && !sts_i.more) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end
        end
      endcase
    end
  end

  assign in_ready_o = ready_q;

endmodule

`default_nettype wire

FILE: src/exp_golomb_bit_writer_unit.sv
// ----------------------------------------------------------------------------
// exp_golomb_bit_writer_unit
// Packs fixed-width fields, Exp-Golomb codes and alignment padding MSB first
// into a byte stream, flagging the last byte produced by each element.
//
//   channel | dir | beat contents
//   --------+-----+----------------------------------------------------------
//   in_i    | in  | mode, bit_count, unsigned_value, signed_value, fill_bit
//   out_o   | out | out_byte, last_byte
//
// One element at a time: accept, then coarse and fine normalize for Golomb
// modes, then packing steps of up to 8 bits (at most 9 steps), one per cycle
// unless stalled. The packing loop sets the rate: ready returns when it ends.
// The output register lets the next element in while the last byte waits.
// A step that completes a byte stalls while the output register is full.
// Reset clears the partial byte and its count; undefined modes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module exp_golomb_bit_writer_unit (
  input wire logic clk_i,
  input wire logic rst_ni,
  ebw_in_if.sink   in_i,
  ebw_out_if.source out_o
);

  ebw_pkg::cmd_t cmd;
  ebw_pkg::sts_t sts;

  ebw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .mode_i     (in_i.mode),
    .sts_i      (sts),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd)
  );

  ebw_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .mode_i           (in_i.mode),
    .bit_count_i      (in_i.bit_count),
    .unsigned_value_i (in_i.unsigned_value),
    .signed_value_i   (in_i.signed_value),
    .fill_bit_i       (in_i.fill_bit),
    .out_ready_i      (out_o.ready),
    .sts_o            (sts),
    .out_valid_o      (out_o.valid),
    .out_byte_o       (out_o.out_byte),
    .last_byte_o      (out_o.last_byte)
  );

  a_coarse_then_fine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.coarse |=> cmd.fine)
    else $error("normalize sequence broken");

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !cmd.step && !cmd.coarse && !cmd.fine)
    else $error("input ready while busy");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready && !sts.can_step) |=> $stable(out_o.out_byte))
    else $error("pending output byte overwritten");

  a_load_clears_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> !in_i.ready)
    else $error("ready held after accept");

endmodule

`default_nettype wire
